@@ rtl/csvds_pkg.sv @@
// ----------------------------------------------------------------------------
// csvds_pkg
// Shared types, constants and helper functions of the CSV delimiter scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package csvds_pkg;

  // Width of the internal byte, comma and row counters.
  localparam int COUNT_BITS = 32;

  // Depth of the queue between the front and the back part.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  // Characters that the scanner recognises.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Marker codes as reported on the result side.
  localparam logic [1:0] MK_NONE  = 2'd0;
  localparam logic [1:0] MK_COMMA = 2'd1;
  localparam logic [1:0] MK_BREAK = 2'd2;

  typedef logic [COUNT_BITS-1:0] count_t;

  // One input item.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  marker_kind;
    logic [31:0] marker_position;
    logic        scan_done;
    logic [31:0] row_count;
    logic [31:0] column_count;
    logic        unterminated_quote;
  } out_item_t;

  // A classified byte, handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] position;
    logic        last;
    logic        unterm;
  } class_item_t;

  // Saturating increment of a counter.
  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == '1) ? v : v + COUNT_BITS'(1);
  endfunction

  // Clamp a counter value to the 32-bit result fields.
  function automatic logic [31:0] clamp_out(input count_t v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'h0000_0000_FFFF_FFFF) begin
      clamp_out = '1;
    end else begin
      clamp_out = w[31:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/csvds_front.sv @@
// ----------------------------------------------------------------------------
// csvds_front
// Accepts bytes, follows quoted sections and classifies each byte as a
// comma, a row break or neither, together with its byte position.
// ----------------------------------------------------------------------------
`default_nettype none

module csvds_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  take,
  input  wire csvds_pkg::in_item_t   item,
  output csvds_pkg::class_item_t     cls
);

  typedef enum logic [2:0] {
    QM_OUTSIDE = 3'd0,
    QM_OPENED  = 3'd1,
    QM_INSIDE  = 3'd2,
    QM_QSEEN   = 3'd3,
    QM_PAIR    = 3'd4
  } qmode_t;

  qmode_t                state_r, state_nxt;
  csvds_pkg::count_t     pos_r, pos_nxt;
  logic [1:0]            kind;
  logic                  is_quote, is_comma, is_break;

  assign is_quote = (item.byte_value == csvds_pkg::CH_QUOTE);
  assign is_comma = (item.byte_value == csvds_pkg::CH_COMMA);
  assign is_break = (item.byte_value == csvds_pkg::CH_LF) ||
                    (item.byte_value == csvds_pkg::CH_CR);

  // Quote state machine and byte classification.
  always_comb begin
    state_nxt = state_r;
    kind      = csvds_pkg::MK_NONE;
    unique case (state_r)
      QM_OPENED: state_nxt = is_quote ? QM_OUTSIDE : QM_INSIDE;
      QM_INSIDE: state_nxt = is_quote ? QM_QSEEN : QM_INSIDE;
      QM_PAIR:   state_nxt = is_quote ? QM_OUTSIDE : QM_INSIDE;
      QM_QSEEN: begin
        if (is_quote) begin
          state_nxt = QM_PAIR;
        end else begin
          // A lone quote closed the section; this byte counts as outside.
          state_nxt = QM_OUTSIDE;
          if (is_comma) begin
            kind = csvds_pkg::MK_COMMA;
          end else if (is_break) begin
            kind = csvds_pkg::MK_BREAK;
          end
        end
      end
      default: begin
        // Outside quotes, and the unused codes behave the same way.
        if (is_quote) begin
          state_nxt = QM_OPENED;
        end else begin
          state_nxt = QM_OUTSIDE;
          if (is_comma) begin
            kind = csvds_pkg::MK_COMMA;
          end else if (is_break) begin
            kind = csvds_pkg::MK_BREAK;
          end
        end
      end
    endcase
  end

  // Classified item for the queue.
  always_comb begin
    cls.kind     = kind;
    cls.position = csvds_pkg::clamp_out(pos_r);
    cls.last     = item.last_byte;
    cls.unterm   = (state_nxt == QM_OPENED) || (state_nxt == QM_INSIDE) ||
                   (state_nxt == QM_PAIR);
  end

  assign pos_nxt = csvds_pkg::sat_inc(pos_r);

  // State and byte position; the final byte starts a fresh file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= QM_OUTSIDE;
      pos_r   <= '0;
    end else if (take) begin
      if (item.last_byte) begin
        state_r <= QM_OUTSIDE;
        pos_r   <= '0;
      end else begin
        state_r <= state_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/csvds_queue.sv @@
// ----------------------------------------------------------------------------
// csvds_queue
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module csvds_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push,
  input  wire csvds_pkg::class_item_t  wr_item,
  output logic                         full,
  input  wire logic                    pop,
  output csvds_pkg::class_item_t       rd_item,
  output logic                         empty
);

  csvds_pkg::class_item_t        mem_r [csvds_pkg::Q_DEPTH];
  logic [csvds_pkg::Q_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [csvds_pkg::Q_AW:0]      count_r;
  logic                          do_push, do_pop;

  assign full    = (count_r == (csvds_pkg::Q_AW+1)'(csvds_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == csvds_pkg::Q_AW'(csvds_pkg::Q_DEPTH - 1)) ?
                    '0 : wr_ptr_r + csvds_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == csvds_pkg::Q_AW'(csvds_pkg::Q_DEPTH - 1)) ?
                    '0 : rd_ptr_r + csvds_pkg::Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (csvds_pkg::Q_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (csvds_pkg::Q_AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/csvds_back.sv @@
// ----------------------------------------------------------------------------
// csvds_back
// Counts commas per row, rows and the widest row, and builds result items
// in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvds_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire csvds_pkg::class_item_t  cls,
  input  wire logic                    cls_valid,
  output logic                         cls_pop,
  output csvds_pkg::out_item_t         out_item,
  output logic                         out_empty,
  input  wire logic                    out_pop
);

  csvds_pkg::count_t     commas_r, commas_nxt;
  csvds_pkg::count_t     widest_r, widest_nxt;
  csvds_pkg::count_t     rows_r, rows_nxt;
  csvds_pkg::count_t     cols_brk, cols_fin;
  csvds_pkg::out_item_t  res_r, res_nxt;
  logic                  valid_r;
  logic                  take;

  // The output register takes a new item whenever it is free or draining.
  assign take      = cls_valid && (!valid_r || out_pop);
  assign cls_pop   = take;
  assign out_empty = !valid_r;
  assign out_item  = res_r;

  // Counter update for one classified byte.
  always_comb begin
    commas_nxt = commas_r;
    widest_nxt = widest_r;
    rows_nxt   = rows_r;
    cols_brk   = csvds_pkg::sat_inc(commas_r);
    if (cls.kind == csvds_pkg::MK_COMMA) begin
      commas_nxt = cols_brk;
    end else if (cls.kind == csvds_pkg::MK_BREAK) begin
      if (cols_brk > widest_r) begin
        widest_nxt = cols_brk;
      end
      commas_nxt = '0;
      rows_nxt   = csvds_pkg::sat_inc(rows_r);
    end
  end

  // Summary for the final byte, taken after this byte's update.
  always_comb begin
    cols_fin = csvds_pkg::sat_inc(commas_nxt);
    if (widest_nxt > cols_fin) begin
      cols_fin = widest_nxt;
    end
    res_nxt.marker_kind        = cls.kind;
    res_nxt.marker_position    = cls.position;
    res_nxt.scan_done          = cls.last;
    res_nxt.row_count          = cls.last ? csvds_pkg::clamp_out(rows_nxt) : '0;
    res_nxt.column_count       = cls.last ? csvds_pkg::clamp_out(cols_fin) : '0;
    res_nxt.unterminated_quote = cls.last && cls.unterm;
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  // Counters and output valid flag; the final byte restarts the counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      commas_r <= '0;
      widest_r <= csvds_pkg::COUNT_BITS'(1);
      rows_r   <= csvds_pkg::COUNT_BITS'(1);
    end else begin
      if (take) begin
        valid_r <= 1'b1;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
      if (take) begin
        if (cls.last) begin
          commas_r <= '0;
          widest_r <= csvds_pkg::COUNT_BITS'(1);
          rows_r   <= csvds_pkg::COUNT_BITS'(1);
        end else begin
          commas_r <= commas_nxt;
          widest_r <= widest_nxt;
          rows_r   <= rows_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/csv_delimiter_scanner_top.sv @@
// ----------------------------------------------------------------------------
// csv_delimiter_scanner_top
// Quote-aware CSV delimiter scanner: one byte in, one result item out.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Item
//   input     in_push / in_full / in_item    byte_value, last_byte
//   result    out_pop / out_empty / out_item marker, position, file summary
//
// One byte is accepted every cycle while in_full is low. A byte taken is
// written into the queue and then into the output register, from which its
// result item can be popped.
// The quote state machine in the front part updates once for each byte taken.
// Reset is synchronous and active low and empties the queue and output register.
// A stalled result side fills the output register and the two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_delimiter_scanner_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire csvds_pkg::in_item_t   in_item,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output csvds_pkg::out_item_t       out_item
);

  csvds_pkg::class_item_t  cls_wr, cls_rd;
  logic                    q_full, q_empty, q_pop;
  logic                    in_take;

  assign in_full = q_full;
  assign in_take = in_push && !q_full;

  // Front part: quote tracking and classification.
  csvds_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (in_take),
    .item  (in_item),
    .cls   (cls_wr)
  );

  // Queue between the two parts.
  csvds_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_take),
    .wr_item (cls_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (cls_rd),
    .empty   (q_empty)
  );

  // Back part: row and column counting and result register.
  csvds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cls       (cls_rd),
    .cls_valid (!q_empty),
    .cls_pop   (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  // After reset no result item is waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result waiting after reset");

  // Summary fields stay zero on items that do not end a file.
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.scan_done) |->
      (out_item.row_count == '0 && out_item.column_count == '0 &&
       !out_item.unterminated_quote))
    else $error("summary fields set before the final byte");

  // A finished file always reports at least one row and one column.
  a_summary_min: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.scan_done) |->
      (out_item.row_count != '0 && out_item.column_count != '0))
    else $error("empty summary on the final byte");

  // The first byte after a finished file sits at position zero.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_item.scan_done) |=>
      (out_empty || out_item.marker_position == '0))
    else $error("byte position not restarted after the final byte");

endmodule

`default_nettype wire
